>>> design/sida_pkg.sv
// ----------------------------------------------------------------------------
// sida_pkg
// Shared constants for the signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sida_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W     = 4 * NUM_DIGITS;
  localparam int unsigned DIG_IDX_W = $clog2(NUM_DIGITS);
  localparam int unsigned BIT_CNT_W = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

endpackage

>>> design/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer into its decimal ASCII text, most
// significant character first, with a leading '-' for negative values.
// ----------------------------------------------------------------------------
// sequence: load the value, run the shift-and-adjust steps, locate the
// leading digit, then one character per cycle while the output is not
// stalled (1 to 11 characters); a new value is taken only after the last
// character, as the 32-step binary-to-bcd loop uses the shared adjust/shift unit
// reset: asynchronous active low, returns to idle with no result pending
module signed_int_to_decimal_ascii (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [sida_pkg::VALUE_W-1:0] value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sida_pkg::CHAR_W-1:0]         character_o,
  output logic                                last_o
);
  import sida_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_FIND,
    S_EMIT
  } state_e;

  state_e               state_q;
  logic [VALUE_W-1:0]   mag_q;
  logic [BCD_W-1:0]     bcd_q;
  logic [BIT_CNT_W-1:0] cnt_q;
  logic [DIG_IDX_W-1:0] dig_q;
  logic                 neg_q;
  logic                 out_valid_q;
  logic [CHAR_W-1:0]    char_q;
  logic                 last_q;

  logic [BCD_W-1:0]     bcd_adj;
  logic [DIG_IDX_W-1:0] top_dig;
  logic [3:0]           cur_nib;
  logic                 out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // add-3 adjust on every bcd nibble of five or more
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // highest non-zero digit, zero when the whole value is zero
  always_comb begin
    top_dig = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        top_dig = DIG_IDX_W'(i);
      end
    end
  end

  assign cur_nib = bcd_q[4*dig_q +: 4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      dig_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      mag_q       <= '0;
      bcd_q       <= '0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      // a new character replaces the one leaving, else a transfer empties the slot
      if ((state_q == S_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            neg_q   <= value_i[VALUE_W-1];
            mag_q   <= value_i[VALUE_W-1] ? (~value_i + VALUE_W'(1)) : value_i;
            bcd_q   <= '0;
            cnt_q   <= '0;
            state_q <= S_CONV;
          end
        end
        S_CONV: begin
          {bcd_q, mag_q} <= {bcd_adj[BCD_W-2:0], mag_q, 1'b0};
          cnt_q <= cnt_q + BIT_CNT_W'(1);
          if (cnt_q == BIT_CNT_W'(VALUE_W - 1)) begin
            state_q <= S_FIND;
          end
        end
        S_FIND: begin
          dig_q   <= top_dig;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (neg_q) begin
              char_q <= ASCII_MINUS;
              last_q <= 1'b0;
              neg_q  <= 1'b0;
            end else begin
              char_q <= ASCII_ZERO + CHAR_W'(cur_nib);
              last_q <= (dig_q == '0);
              if (dig_q == '0) begin
                state_q <= S_IDLE;
              end else begin
                dig_q <= dig_q - DIG_IDX_W'(1);
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
